@@ rtl/core/stmr_pkg.sv @@
// Package for the serial time message receiver: operation codes, character
// codes, message byte positions and calendar tables. No dependencies.
package stmr_pkg;

   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,
      OP_GAP  = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   typedef logic [6:0] field_type;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_G      = 8'h47;
   localparam logic [7:0] CHAR_P      = 8'h50;
   localparam logic [7:0] CHAR_S      = 8'h53;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_FIX    = 8'h41;
   localparam logic [7:0] CHAR_POWER  = 8'h31;

   localparam int POS_DOLLAR     = 0;
   localparam int POS_G          = 1;
   localparam int POS_P          = 2;
   localparam int POS_S          = 3;
   localparam int POS_HH_TENS    = 4;
   localparam int POS_HH_UNITS   = 5;
   localparam int POS_MI_TENS    = 6;
   localparam int POS_MI_UNITS   = 7;
   localparam int POS_SS_TENS    = 8;
   localparam int POS_SS_UNITS   = 9;
   localparam int POS_DD_TENS    = 10;
   localparam int POS_DD_UNITS   = 11;
   localparam int POS_MO_TENS    = 12;
   localparam int POS_MO_UNITS   = 13;
   localparam int POS_YY_TENS    = 14;
   localparam int POS_YY_UNITS   = 15;
   localparam int POS_FIX_ONE    = 16;
   localparam int POS_FIX_TWO    = 17;
   localparam int POS_POWER_ONE  = 18;
   localparam int POS_POWER_TWO  = 19;
   localparam int POS_DIGIT_LAST = POS_YY_UNITS;

   localparam logic [15:0] DAYS_TO_2000    = 16'd10957;
   localparam logic [31:0] SECONDS_PER_DAY = 32'd86400;
   localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;
   localparam logic [6:0]  TIMEOUT_RESET   = 7'd30;

   function automatic logic [8:0] days_before_month(input field_type month);
      logic [8:0] d;
      case (month)
         7'd1:    d = 9'd0;
         7'd2:    d = 9'd31;
         7'd3:    d = 9'd59;
         7'd4:    d = 9'd90;
         7'd5:    d = 9'd120;
         7'd6:    d = 9'd151;
         7'd7:    d = 9'd181;
         7'd8:    d = 9'd212;
         7'd9:    d = 9'd243;
         7'd10:   d = 9'd273;
         7'd11:   d = 9'd304;
         7'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   function automatic logic [4:0] month_length(input field_type month, input logic leap);
      logic [4:0] d;
      case (month)
         7'd2:    d = leap ? 5'd29 : 5'd28;
         7'd4:    d = 5'd30;
         7'd6:    d = 5'd30;
         7'd9:    d = 5'd30;
         7'd11:   d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

@@ rtl/core/serial_time_message_receiver.sv @@
// Serial time message receiver: collects a fixed-format time message byte by
// byte and reports Unix/NTP seconds, status flags and signal loss. Uses stmr_pkg.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_operation, req_data_byte
//   rsp      out        rsp_valid/rsp_stall  accepted, seconds, flags, lost
//   csr      in         csr_write_enable     csr_write_data (timeout seconds)
//
// One transaction per cycle while req_stall is low; results pass the input stage
// and the result register. Date arithmetic is spread over the arrival of bytes
// 10 and 16..18, so each stage holds at most two constant multiplies and a few
// adds. Synchronous reset; no clearing pass. A stall on rsp holds the result and
// backs up into req only when the staged transaction needs the output slot.
module serial_time_message_receiver #(
   parameter int MESSAGE_LENGTH = 20
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_message_accepted,
   output logic [31:0] rsp_unix_seconds,
   output logic [31:0] rsp_ntp_seconds,
   output logic       rsp_fix_one_ok,
   output logic       rsp_fix_two_ok,
   output logic       rsp_power_one_ok,
   output logic       rsp_power_two_ok,
   output logic       rsp_signal_lost,
   input  logic       csr_write_enable,
   input  stmr_pkg::field_type csr_write_data
);
   import stmr_pkg::*;

   localparam int POS_W = $clog2(MESSAGE_LENGTH + 1);
   localparam logic [POS_W-1:0] POS_FULL = POS_W'(MESSAGE_LENGTH);

   // input stage
   logic       s_valid_ff;
   logic [1:0] s_op_ff;
   logic [7:0] s_byte_ff;
   logic       s_emits, out_free, fire;

   // configuration
   field_type  timeout_ff;

   // message reception
   logic [POS_W-1:0] pos_ff, pos_in;
   logic       header_ok_ff, header_ok_in;
   logic       format_err_ff, format_err_in;
   logic [3:0] tens_ff, tens_in;
   field_type  hh_ff, hh_in, mi_ff, mi_in, ss_ff, ss_in;
   field_type  dd_ff, dd_in, mo_ff, mo_in, yy_ff, yy_in;
   logic [16:0] sod_ff, sod_in;
   logic [15:0] days_ff, days_in;
   logic [31:0] cand_unix_ff, cand_unix_in;
   logic [31:0] cand_ntp_ff, cand_ntp_in;
   logic [3:0] cand_flags_ff, cand_flags_in;

   // architectural state
   logic [31:0] last_unix_ff, last_unix_in;
   logic [31:0] last_ntp_ff, last_ntp_in;
   logic [3:0] flags_ff, flags_in;
   field_type  count_ff, count_in;
   logic       lost_ff, lost_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_accepted_ff, rsp_accepted_in;

   logic [7:0] c;
   logic [3:0] digit;
   logic       is_digit, leap, msg_ok;
   field_type  pair;
   field_type  tick_count;
   int         pos_int;

   assign s_emits  = s_valid_ff && (s_op_ff == OP_GAP || s_op_ff == OP_TICK);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = s_valid_ff && (!s_emits || out_free);
   assign req_stall = s_valid_ff && !fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         s_op_ff   <= req_operation;
         s_byte_ff <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         timeout_ff <= csr_write_data;
      end
   end

   always_comb begin
      c        = s_byte_ff;
      digit    = c[3:0];
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      pair     = 7'(7'(tens_ff) * 7'd10) + 7'(digit);
      pos_int  = int'(pos_ff);
      leap     = (yy_ff[1:0] == 2'd0);
      msg_ok   = (pos_ff == POS_FULL) && header_ok_ff && !format_err_ff &&
                 (hh_ff <= 7'd23) && (mi_ff <= 7'd59) && (ss_ff <= 7'd59) &&
                 (mo_ff >= 7'd1) && (mo_ff <= 7'd12) && (dd_ff >= 7'd1) &&
                 (dd_ff <= 7'(month_length(mo_ff, leap)));
      tick_count = (count_ff != 7'd0) ? count_ff - 7'd1 : 7'd0;

      pos_in        = pos_ff;
      header_ok_in  = header_ok_ff;
      format_err_in = format_err_ff;
      tens_in       = tens_ff;
      hh_in         = hh_ff;
      mi_in         = mi_ff;
      ss_in         = ss_ff;
      dd_in         = dd_ff;
      mo_in         = mo_ff;
      yy_in         = yy_ff;
      sod_in        = sod_ff;
      days_in       = days_ff;
      cand_unix_in  = cand_unix_ff;
      cand_ntp_in   = cand_ntp_ff;
      cand_flags_in = cand_flags_ff;
      last_unix_in  = last_unix_ff;
      last_ntp_in   = last_ntp_ff;
      flags_in      = flags_ff;
      count_in      = count_ff;
      lost_in       = lost_ff;
      rsp_accepted_in = 1'b0;

      if (fire) begin
         case (s_op_ff)
            OP_BYTE: begin
               if (pos_ff != POS_FULL) begin
                  pos_in = pos_ff + POS_W'(1);
                  if (pos_int >= POS_HH_TENS && pos_int <= POS_DIGIT_LAST && !is_digit) begin
                     format_err_in = 1'b1;
                  end
                  case (pos_int)
                     POS_DOLLAR: begin
                        if (c != CHAR_DOLLAR) header_ok_in = 1'b0;
                     end
                     POS_G: begin
                        if (c != CHAR_G && c != CHAR_G + CASE_OFFSET) header_ok_in = 1'b0;
                     end
                     POS_P: begin
                        if (c != CHAR_P && c != CHAR_P + CASE_OFFSET) header_ok_in = 1'b0;
                     end
                     POS_S: begin
                        if (c != CHAR_S && c != CHAR_S + CASE_OFFSET) header_ok_in = 1'b0;
                     end
                     POS_HH_TENS, POS_MI_TENS, POS_SS_TENS, POS_MO_TENS, POS_YY_TENS: begin
                        tens_in = digit;
                     end
                     POS_DD_TENS: begin
                        tens_in = digit;
                        sod_in  = 17'(17'(hh_ff) * 17'd3600) + 17'(17'(mi_ff) * 17'd60) +
                                  17'(ss_ff);
                     end
                     POS_HH_UNITS: hh_in = pair;
                     POS_MI_UNITS: mi_in = pair;
                     POS_SS_UNITS: ss_in = pair;
                     POS_DD_UNITS: dd_in = pair;
                     POS_MO_UNITS: mo_in = pair;
                     POS_YY_UNITS: yy_in = pair;
                     POS_FIX_ONE: begin
                        cand_flags_in[0] = (c == CHAR_FIX);
                        days_in = DAYS_TO_2000 + 16'(16'(yy_ff) * 16'd365) +
                                  16'((8'(yy_ff) + 8'd3) >> 2) +
                                  16'(days_before_month(mo_ff)) +
                                  16'((leap && mo_ff > 7'd2) ? 1 : 0) +
                                  16'(dd_ff) - 16'd1;
                     end
                     POS_FIX_TWO: begin
                        cand_flags_in[1] = (c == CHAR_FIX);
                        cand_unix_in = 32'(32'(days_ff) * SECONDS_PER_DAY) + 32'(sod_ff);
                     end
                     POS_POWER_ONE: begin
                        cand_flags_in[2] = (c == CHAR_POWER);
                        cand_ntp_in = cand_unix_ff + NTP_UNIX_OFFSET;
                     end
                     POS_POWER_TWO: cand_flags_in[3] = (c == CHAR_POWER);
                     default: ;
                  endcase
               end
            end
            OP_GAP: begin
               pos_in        = '0;
               header_ok_in  = 1'b1;
               format_err_in = 1'b0;
               tens_in       = 4'd0;
               rsp_accepted_in = msg_ok;
               if (msg_ok) begin
                  last_unix_in = cand_unix_ff;
                  last_ntp_in  = cand_ntp_ff;
                  flags_in     = cand_flags_ff;
                  count_in     = timeout_ff;
                  lost_in      = 1'b0;
               end
            end
            OP_TICK: begin
               count_in = tick_count;
               if (tick_count == 7'd0) lost_in = 1'b1;
            end
            default: ;
         endcase
      end

      if (fire && s_emits) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         header_ok_ff  <= 1'b1;
         format_err_ff <= 1'b0;
         tens_ff       <= 4'd0;
         last_unix_ff  <= 32'd0;
         last_ntp_ff   <= NTP_UNIX_OFFSET;
         flags_ff      <= 4'd0;
         count_ff      <= TIMEOUT_RESET;
         lost_ff       <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         header_ok_ff  <= header_ok_in;
         format_err_ff <= format_err_in;
         tens_ff       <= tens_in;
         last_unix_ff  <= last_unix_in;
         last_ntp_ff   <= last_ntp_in;
         flags_ff      <= flags_in;
         count_ff      <= count_in;
         lost_ff       <= lost_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      hh_ff         <= hh_in;
      mi_ff         <= mi_in;
      ss_ff         <= ss_in;
      dd_ff         <= dd_in;
      mo_ff         <= mo_in;
      yy_ff         <= yy_in;
      sod_ff        <= sod_in;
      days_ff       <= days_in;
      cand_unix_ff  <= cand_unix_in;
      cand_ntp_ff   <= cand_ntp_in;
      cand_flags_ff <= cand_flags_in;
      if (fire && s_emits) begin
         rsp_accepted_ff  <= rsp_accepted_in;
         rsp_unix_seconds <= last_unix_in;
         rsp_ntp_seconds  <= last_ntp_in;
         rsp_fix_one_ok   <= flags_in[0];
         rsp_fix_two_ok   <= flags_in[1];
         rsp_power_one_ok <= flags_in[2];
         rsp_power_two_ok <= flags_in[3];
         rsp_signal_lost  <= lost_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_message_accepted = rsp_accepted_ff;

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for serial_time_message_receiver: sends time messages, gaps and
// one-second ticks, predicts each result in-bench and checks every field.
// Depends on stmr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module tb_top;
   import stmr_pkg::*;

   localparam int MSG_LEN = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [1:0] OP_NONE = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data;
   } link_item_t;

   typedef struct packed {
      logic        accepted;
      logic [31:0] unix_s;
      logic [31:0] ntp_s;
      logic        fix_one;
      logic        fix_two;
      logic        power_one;
      logic        power_two;
      logic        lost;
   } time_report_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_operation = OP_BYTE;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_message_accepted;
   logic [31:0] rsp_unix_seconds;
   logic [31:0] rsp_ntp_seconds;
   logic       rsp_fix_one_ok;
   logic       rsp_fix_two_ok;
   logic       rsp_power_one_ok;
   logic       rsp_power_two_ok;
   logic       rsp_signal_lost;
   logic       csr_write_enable = 1'b0;
   field_type  csr_write_data = TIMEOUT_RESET;

   link_item_t   link_items[$];
   time_report_t predicted_reports[$];
   logic [7:0]   msg_buf [0:MSG_LEN-1];
   int           items_queued = 0;
   int           mismatch_count = 0;
   int           stuck_cycles = 0;
   int           send_idle = 0;
   int           stall_left = 0;
   logic         quiet_tail = 1'b0;

   // receiver state as predicted by the bench
   field_type    timeout_model = TIMEOUT_RESET;
   logic [7:0]   rx_msg [0:MSG_LEN-1];
   int           rx_count = 0;
   logic [31:0]  last_unix = '0;
   logic [3:0]   held_flags = '0;
   logic [6:0]   lost_count = TIMEOUT_RESET;
   logic         signal_lost = 1'b1;

   serial_time_message_receiver dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_data_byte        (req_data_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_message_accepted (rsp_message_accepted),
      .rsp_unix_seconds     (rsp_unix_seconds),
      .rsp_ntp_seconds      (rsp_ntp_seconds),
      .rsp_fix_one_ok       (rsp_fix_one_ok),
      .rsp_fix_two_ok       (rsp_fix_two_ok),
      .rsp_power_one_ok     (rsp_power_one_ok),
      .rsp_power_two_ok     (rsp_power_two_ok),
      .rsp_signal_lost      (rsp_signal_lost),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int days_in_month(input int mo, input int yy);
      case (mo)
         2:          return (yy % 4 == 0) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:    return 31;
      endcase
   endfunction

   function automatic logic letter_match(input logic [7:0] c, input logic [7:0] upper);
      return c == upper || c == upper + CASE_OFFSET;
   endfunction

   function automatic int digit_pair(input int p);
      return int'(rx_msg[p] - CHAR_ZERO) * 10 + int'(rx_msg[p + 1] - CHAR_ZERO);
   endfunction

   task automatic predict_item(input logic [1:0] op, input logic [7:0] ch);
      time_report_t r;
      int hh, mi, ss, dd, mo, yy;
      logic ok;
      logic [31:0] days;
      ok = 1'b0;
      case (op)
         OP_BYTE: begin
            if (rx_count < MSG_LEN) begin
               rx_msg[rx_count] = ch;
               rx_count++;
            end
         end
         OP_GAP: begin
            ok = rx_count >= MSG_LEN && rx_msg[POS_DOLLAR] == CHAR_DOLLAR &&
                 letter_match(rx_msg[POS_G], CHAR_G) && letter_match(rx_msg[POS_P], CHAR_P) &&
                 letter_match(rx_msg[POS_S], CHAR_S);
            for (int i = POS_HH_TENS; i <= POS_DIGIT_LAST; i++)
               if (rx_msg[i] < CHAR_ZERO || rx_msg[i] > CHAR_NINE) ok = 1'b0;
            hh = digit_pair(POS_HH_TENS);
            mi = digit_pair(POS_MI_TENS);
            ss = digit_pair(POS_SS_TENS);
            dd = digit_pair(POS_DD_TENS);
            mo = digit_pair(POS_MO_TENS);
            yy = digit_pair(POS_YY_TENS);
            if (ok && (hh > 23 || mi > 59 || ss > 59 || mo < 1 || mo > 12)) ok = 1'b0;
            if (ok && (dd < 1 || dd > days_in_month(mo, yy))) ok = 1'b0;
            if (ok) begin
               days = DAYS_TO_2000 + 365 * yy + (yy + 3) / 4 + dd - 1;
               for (int m = 1; m < mo; m++) days += days_in_month(m, yy);
               last_unix = days * SECONDS_PER_DAY + hh * 3600 + mi * 60 + ss;
               held_flags = {rx_msg[POS_FIX_ONE] == CHAR_FIX, rx_msg[POS_FIX_TWO] == CHAR_FIX,
                             rx_msg[POS_POWER_ONE] == CHAR_POWER,
                             rx_msg[POS_POWER_TWO] == CHAR_POWER};
               lost_count = timeout_model;
               signal_lost = 1'b0;
            end
            rx_count = 0;
         end
         OP_TICK: begin
            if (lost_count != 0) lost_count--;
            if (lost_count == 0) signal_lost = 1'b1;
         end
         default: ;
      endcase
      if (op == OP_GAP || op == OP_TICK) begin
         r = {ok, last_unix, last_unix + NTP_UNIX_OFFSET, held_flags, signal_lost};
         predicted_reports.push_back(r);
      end
   endtask

   function automatic void log_mismatch(input string what, input time_report_t want,
                                        input time_report_t seen);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t %s: expected acc=%b unix=%0d ntp=%0d fix=%b%b pwr=%b%b lost=%b",
                  $time, what, want.accepted, want.unix_s, want.ntp_s, want.fix_one,
                  want.fix_two, want.power_one, want.power_two, want.lost);
         $display("   got acc=%b unix=%0d ntp=%0d fix=%b%b pwr=%b%b lost=%b",
                  seen.accepted, seen.unix_s, seen.ntp_s, seen.fix_one, seen.fix_two,
                  seen.power_one, seen.power_two, seen.lost);
      end
   endfunction

   always @(posedge clock) begin : driver
      link_item_t next_item;
      if (reset) begin
         req_valid <= 1'b0;
         send_idle <= 0;
      end else begin
         if (req_valid && !req_stall) predict_item(req_operation, req_data_byte);
         if (!req_valid || !req_stall) begin
            if (send_idle != 0) begin
               send_idle <= send_idle - 1;
               req_valid <= 1'b0;
            end else if (link_items.size() != 0 && !quiet_tail && $urandom_range(0, 5) == 0) begin
               send_idle <= $urandom_range(0, 3);
               req_valid <= 1'b0;
            end else if (link_items.size() != 0) begin
               next_item = link_items.pop_front();
               req_operation <= next_item.op;
               req_data_byte <= next_item.data;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      time_report_t seen, want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_message_accepted, rsp_unix_seconds, rsp_ntp_seconds, rsp_fix_one_ok,
                    rsp_fix_two_ok, rsp_power_one_ok, rsp_power_two_ok, rsp_signal_lost};
            if (predicted_reports.size() == 0) begin
               log_mismatch("unexpected result", '0, seen);
            end else begin
               want = predicted_reports.pop_front();
               if (seen.accepted !== want.accepted || seen.unix_s !== want.unix_s ||
                   seen.ntp_s !== want.ntp_s || seen.fix_one !== want.fix_one ||
                   seen.fix_two !== want.fix_two || seen.power_one !== want.power_one ||
                   seen.power_two !== want.power_two || seen.lost !== want.lost)
                  log_mismatch("mismatch", want, seen);
            end
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin : watchdog
      wait (stuck_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   function automatic void push_op(input logic [1:0] op, input logic [7:0] ch);
      link_items.push_back(link_item_t'{op, ch});
      if (op != OP_NONE) items_queued++;
   endfunction

   function automatic void put_pair(input int p, input int v);
      msg_buf[p] = CHAR_ZERO + 8'(v / 10);
      msg_buf[p + 1] = CHAR_ZERO + 8'(v % 10);
   endfunction

   function automatic logic [7:0] status_char(input logic [7:0] good);
      return ($urandom_range(0, 3) != 0) ? good : 8'($urandom);
   endfunction

   function automatic void compose_message(input int hh, mi, ss, dd, mo, yy);
      msg_buf[POS_DOLLAR] = CHAR_DOLLAR;
      msg_buf[POS_G] = CHAR_G | ($urandom_range(0, 1) ? CASE_OFFSET : 8'h00);
      msg_buf[POS_P] = CHAR_P | ($urandom_range(0, 1) ? CASE_OFFSET : 8'h00);
      msg_buf[POS_S] = CHAR_S | ($urandom_range(0, 1) ? CASE_OFFSET : 8'h00);
      put_pair(POS_HH_TENS, hh);
      put_pair(POS_MI_TENS, mi);
      put_pair(POS_SS_TENS, ss);
      put_pair(POS_DD_TENS, dd);
      put_pair(POS_MO_TENS, mo);
      put_pair(POS_YY_TENS, yy);
      msg_buf[POS_FIX_ONE] = status_char(CHAR_FIX);
      msg_buf[POS_FIX_TWO] = status_char(CHAR_FIX);
      msg_buf[POS_POWER_ONE] = status_char(CHAR_POWER);
      msg_buf[POS_POWER_TWO] = status_char(CHAR_POWER);
   endfunction

   function automatic void random_fix();
      int mo, yy;
      yy = $urandom_range(0, 99);
      mo = $urandom_range(1, 12);
      compose_message($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                      $urandom_range(1, days_in_month(mo, yy)), mo, yy);
   endfunction

   function automatic void send_message(input int len);
      for (int i = 0; i < len; i++)
         push_op(OP_BYTE, (i < MSG_LEN) ? msg_buf[i] : 8'($urandom));
      push_op(OP_GAP, 8'($urandom));
   endfunction

   function automatic void random_traffic(input int n_items);
      int start, pick;
      start = items_queued;
      while (items_queued - start < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            random_fix();
            send_message(MSG_LEN);
         end else if (pick < 68) begin
            random_fix();
            msg_buf[$urandom_range(0, MSG_LEN - 1)] = 8'($urandom);
            send_message(MSG_LEN);
         end else if (pick < 76) begin
            random_fix();
            send_message($urandom_range(0, MSG_LEN + 6));
         end else if (pick < 81) begin
            compose_message($urandom_range(0, 99), $urandom_range(0, 99), $urandom_range(0, 99),
                            $urandom_range(0, 99), $urandom_range(0, 99), $urandom_range(0, 99));
            send_message(MSG_LEN);
         end else if (pick < 95) begin
            repeat ($urandom_range(1, 6)) push_op(OP_TICK, 8'($urandom));
         end else begin
            repeat ($urandom_range(1, 3)) push_op(2'($urandom_range(0, 3)), 8'($urandom));
            push_op(OP_GAP, 8'($urandom));
         end
      end
   endfunction

   task automatic drain();
      while (link_items.size() != 0 || req_valid || predicted_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_timeout(input field_type secs);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= secs;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      timeout_model = secs;
   endtask

   initial begin : stimulus
      field_type timeout_plan [0:5];
      timeout_plan[0] = 7'd127;
      timeout_plan[1] = 7'd1;
      timeout_plan[2] = 7'd0;
      timeout_plan[3] = field_type'($urandom_range(2, 15));
      timeout_plan[4] = field_type'($urandom_range(1, 127));
      timeout_plan[5] = 7'd5;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset state, ignored op, empty gap, date extremes, range and format errors
      push_op(OP_TICK, 8'hFF);
      push_op(OP_NONE, 8'hFF);
      push_op(OP_GAP, 8'h00);
      compose_message(23, 59, 59, 31, 12, 99);
      msg_buf[POS_FIX_ONE] = CHAR_FIX;
      msg_buf[POS_FIX_TWO] = CHAR_FIX;
      msg_buf[POS_POWER_ONE] = CHAR_POWER;
      msg_buf[POS_POWER_TWO] = CHAR_POWER;
      send_message(MSG_LEN);
      compose_message(0, 0, 0, 1, 1, 0);
      msg_buf[POS_FIX_ONE] = CHAR_FIX | CASE_OFFSET;
      msg_buf[POS_FIX_TWO] = 8'h00;
      msg_buf[POS_POWER_ONE] = CHAR_ZERO;
      msg_buf[POS_POWER_TWO] = 8'hFF;
      send_message(MSG_LEN);
      compose_message(12, 0, 0, 29, 2, 24);
      send_message(MSG_LEN);
      compose_message(12, 0, 0, 29, 2, 23);
      send_message(MSG_LEN);
      compose_message(0, 0, 0, 31, 4, 10);
      send_message(MSG_LEN);
      compose_message(0, 0, 0, 0, 5, 10);
      send_message(MSG_LEN);
      compose_message(0, 0, 0, 1, 0, 10);
      send_message(MSG_LEN);
      compose_message(0, 0, 0, 1, 13, 10);
      send_message(MSG_LEN);
      compose_message(24, 0, 0, 1, 1, 10);
      send_message(MSG_LEN);
      compose_message(0, 60, 0, 1, 1, 10);
      send_message(MSG_LEN);
      compose_message(0, 0, 60, 1, 1, 10);
      send_message(MSG_LEN);
      random_fix();
      msg_buf[POS_MI_TENS] = CHAR_NINE + 8'd1;
      send_message(MSG_LEN);
      random_fix();
      msg_buf[POS_DIGIT_LAST] = CHAR_ZERO - 8'd1;
      send_message(MSG_LEN);
      random_fix();
      msg_buf[POS_DOLLAR] = CHAR_DOLLAR - 8'd1;
      send_message(MSG_LEN);
      random_fix();
      msg_buf[POS_S] = CHAR_S + 8'd1;
      send_message(MSG_LEN);
      random_fix();
      send_message(MSG_LEN - 1);
      random_fix();
      send_message(MSG_LEN + 5);
      push_op(OP_TICK, 8'h00);
      push_op(OP_TICK, 8'h55);

      foreach (timeout_plan[i]) begin
         set_timeout(timeout_plan[i]);
         if (i == 5) quiet_tail = 1'b1;
         random_traffic(180);
      end

      drain();
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ serial_time_message_receiver.f @@
rtl/core/stmr_pkg.sv
rtl/core/serial_time_message_receiver.sv
tb/tb_top.sv
